// ===== sv/bzp_pkg.sv =====
// ----------------------------------------------------------------------------
// bzp_pkg
// Shared types and constants for the cubic Bezier point sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package bzp_pkg;

   localparam int IDX_W    = 7;
   localparam int COORD_W  = 12;
   localparam int POINT_W  = 13;
   localparam int FRAC_BITS = 16;
   localparam int T_W      = FRAC_BITS + 1;
   localparam int SQ_W     = 2 * FRAC_BITS + 1;
   localparam int COEF_W   = 3 * FRAC_BITS + 1;
   localparam int PROD_W   = COEF_W + COORD_W;
   localparam int RND_W    = PROD_W - 3 * FRAC_BITS;
   localparam int NUM_REGS = 8;
   localparam int REG_IDX_W = 3;

   localparam logic [T_W-1:0] ONE_Q16 = T_W'(1) << FRAC_BITS;

   localparam logic [REG_IDX_W-1:0] REG_START_X    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_START_Y    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_PULL_ONE_X = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_PULL_ONE_Y = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_PULL_TWO_X = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_PULL_TWO_Y = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_FINISH_X   = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_FINISH_Y   = 3'd7;

   // index 0: start point weight (u^3) ... index 3: finish point weight (t^3)
   typedef logic [3:0][COEF_W-1:0]  coef_set_type;
   typedef logic [3:0][COORD_W-1:0] coord_set_type;

   typedef struct packed {
      logic en_prod;
      logic en_round;
      logic en_sum;
   } pipe_ctl_type;

endpackage

`default_nettype wire

// ===== sv/bzp_coef.sv =====
// ----------------------------------------------------------------------------
// bzp_coef
// Three-stage pipeline: sample index to t, then u^2/ut/t^2, then the four
// Bernstein weights with 48 fractional bits.
// ----------------------------------------------------------------------------
`default_nettype none

module bzp_coef #(
   parameter int SEGMENTS = 100
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire logic [bzp_pkg::IDX_W-1:0]   in_index,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output bzp_pkg::coef_set_type            out_coef
);

   localparam int T_W    = bzp_pkg::T_W;
   localparam int SQ_W   = bzp_pkg::SQ_W;
   localparam int COEF_W = bzp_pkg::COEF_W;
   localparam int DEPTH  = 2 ** bzp_pkg::IDX_W;

   logic [T_W-1:0] t_rom [DEPTH];

   for (genvar g = 0; g < DEPTH; g++) begin : g_trom
      localparam int TQ = ((g << (bzp_pkg::FRAC_BITS + 1)) + SEGMENTS) / (2 * SEGMENTS);
      localparam int TS = (g >= SEGMENTS || TQ > (1 << bzp_pkg::FRAC_BITS)) ?
                          (1 << bzp_pkg::FRAC_BITS) : TQ;
      assign t_rom[g] = T_W'(TS);
   end

   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;
   logic [T_W-1:0]  t1_ff, u1_ff, t2_ff, u2_ff;
   logic [SQ_W-1:0] uu2_ff, ut2_ff, tt2_ff;
   logic [SQ_W-1:0] uu_in, ut_in, tt_in;
   logic [COEF_W-1:0] c1_raw, c2_raw;
   bzp_pkg::coef_set_type coef_ff, coef_in;
   logic [T_W-1:0] t_in;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   assign t_in  = t_rom[in_index];
   assign uu_in = SQ_W'((2 * T_W)'(u1_ff) * (2 * T_W)'(u1_ff));
   assign ut_in = SQ_W'((2 * T_W)'(u1_ff) * (2 * T_W)'(t1_ff));
   assign tt_in = SQ_W'((2 * T_W)'(t1_ff) * (2 * T_W)'(t1_ff));

   assign c1_raw = COEF_W'((SQ_W + T_W)'(ut2_ff) * (SQ_W + T_W)'(u2_ff));
   assign c2_raw = COEF_W'((SQ_W + T_W)'(tt2_ff) * (SQ_W + T_W)'(u2_ff));

   always_comb begin
      coef_in[0] = COEF_W'((SQ_W + T_W)'(uu2_ff) * (SQ_W + T_W)'(u2_ff));
      coef_in[1] = (c1_raw << 1) + c1_raw;
      coef_in[2] = (c2_raw << 1) + c2_raw;
      coef_in[3] = COEF_W'((SQ_W + T_W)'(tt2_ff) * (SQ_W + T_W)'(t2_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         t1_ff <= t_in;
         u1_ff <= bzp_pkg::ONE_Q16 - t_in;
      end
      if (rdy2) begin
         t2_ff  <= t1_ff;
         u2_ff  <= u1_ff;
         uu2_ff <= uu_in;
         ut2_ff <= ut_in;
         tt2_ff <= tt_in;
      end
      if (rdy3) coef_ff <= coef_in;
   end

   assign out_valid = v3_ff;
   assign out_coef  = coef_ff;

`ifndef NO_ASSERTIONS
   // weights sum to one; u*t peaks at t = 1/2
   a_weights_sum: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (50'(coef_ff[0]) + 50'(coef_ff[1]) + 50'(coef_ff[2]) + 50'(coef_ff[3]))
                == (50'(1) << (3 * bzp_pkg::FRAC_BITS)))
      else $error("bzp_coef: weights do not sum to one");
   a_uv_cross: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> ut2_ff <= (SQ_W'(1) << (2 * bzp_pkg::FRAC_BITS - 2)))
      else $error("bzp_coef: u*t out of range");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !out_ready) |=> (v3_ff && $stable(coef_ff)))
      else $error("bzp_coef: stalled weights changed");
`endif

endmodule

`default_nettype wire

// ===== sv/bzp_term.sv =====
// ----------------------------------------------------------------------------
// bzp_term
// One axis: weight times coordinate, rounding of each term half away from
// zero, and the sum of the four rounded terms. Three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module bzp_term (
   input  wire logic                          clock,
   input  bzp_pkg::pipe_ctl_type              ctl,
   input  bzp_pkg::coef_set_type              coef,
   input  bzp_pkg::coord_set_type             coord,
   output logic [bzp_pkg::POINT_W-1:0]        point
);

   localparam int COORD_W = bzp_pkg::COORD_W;
   localparam int COEF_W  = bzp_pkg::COEF_W;
   localparam int PROD_W  = bzp_pkg::PROD_W;
   localparam int RND_W   = bzp_pkg::RND_W;
   localparam int POINT_W = bzp_pkg::POINT_W;
   localparam int SHIFT   = 3 * bzp_pkg::FRAC_BITS;

   logic [3:0][PROD_W-1:0]  prod_ff, prod_in;
   logic [3:0]              neg_ff;
   logic [3:0][RND_W-1:0]   term_ff, term_in;
   logic [POINT_W-1:0]      sum_ff;
   logic [RND_W+1:0]        sum_in;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         prod_in[k] = PROD_W'(coord[k][COORD_W-1] ? COORD_W'(-coord[k]) : coord[k])
                      * PROD_W'(coef[k]);
      end
   end

   always_comb begin
      logic [PROD_W-1:0] rounded;
      for (int k = 0; k < 4; k++) begin
         rounded    = prod_ff[k] + (PROD_W'(1) << (SHIFT - 1));
         term_in[k] = neg_ff[k] ? RND_W'(-rounded[PROD_W-1:SHIFT])
                                : rounded[PROD_W-1:SHIFT];
      end
   end

   assign sum_in = {{2{term_ff[0][RND_W-1]}}, term_ff[0]}
                 + {{2{term_ff[1][RND_W-1]}}, term_ff[1]}
                 + {{2{term_ff[2][RND_W-1]}}, term_ff[2]}
                 + {{2{term_ff[3][RND_W-1]}}, term_ff[3]};

   always_ff @(posedge clock) begin
      if (ctl.en_prod) begin
         prod_ff <= prod_in;
         for (int k = 0; k < 4; k++) neg_ff[k] <= coord[k][COORD_W-1];
      end
      if (ctl.en_round) term_ff <= term_in;
      if (ctl.en_sum)   sum_ff  <= POINT_W'(sum_in);
   end

   assign point = sum_ff;

endmodule

`default_nettype wire

// ===== sv/cubic_bezier_point_sampler.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_point_sampler
// Evaluates a cubic Bezier curve at t = sample_index / SEGMENTS and returns
// the integer point, each Bernstein term rounded half away from zero.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*  : write one control point coordinate per beat (index 0..7 =
//            start_x/y, pull_one_x/y, pull_two_x/y, finish_x/y). Always ready.
//            Write only while no sample is in flight.
//   req_*  : one sample index per beat; indexes above SEGMENTS give the end.
//   rsp_*  : one point per beat, in request order.
// A request passes six register stages before rsp_valid: t lookup, squares,
// weights, products, rounding, sum. Throughput is one point per cycle while rsp_ready is high.
// Each stage holds its own valid bit; when the receiver stalls the output
// register holds, empty stages further up keep filling, and req_ready drops
// once all six stages are full.
// Reset clears all stage valid bits and all control points to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_point_sampler #(
   parameter int SEGMENTS = 100
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [bzp_pkg::REG_IDX_W-1:0]      csr_index,
   input  wire logic [bzp_pkg::COORD_W-1:0]        csr_data,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [bzp_pkg::IDX_W-1:0]          req_sample_index,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [bzp_pkg::POINT_W-1:0]      rsp_point_x,
   output logic signed [bzp_pkg::POINT_W-1:0]      rsp_point_y
);

   logic [bzp_pkg::COORD_W-1:0] cfg_ff [bzp_pkg::NUM_REGS];

   logic                    coef_valid, coef_ready;
   bzp_pkg::coef_set_type   coef;
   bzp_pkg::coord_set_type  coord_x, coord_y;
   bzp_pkg::pipe_ctl_type   ctl;
   logic                    v4_ff, v5_ff, v6_ff;
   logic                    rdy4, rdy5, rdy6;
   logic [bzp_pkg::POINT_W-1:0] point_x, point_y;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < bzp_pkg::NUM_REGS; k++) cfg_ff[k] <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            bzp_pkg::REG_START_X:    cfg_ff[bzp_pkg::REG_START_X]    <= csr_data;
            bzp_pkg::REG_START_Y:    cfg_ff[bzp_pkg::REG_START_Y]    <= csr_data;
            bzp_pkg::REG_PULL_ONE_X: cfg_ff[bzp_pkg::REG_PULL_ONE_X] <= csr_data;
            bzp_pkg::REG_PULL_ONE_Y: cfg_ff[bzp_pkg::REG_PULL_ONE_Y] <= csr_data;
            bzp_pkg::REG_PULL_TWO_X: cfg_ff[bzp_pkg::REG_PULL_TWO_X] <= csr_data;
            bzp_pkg::REG_PULL_TWO_Y: cfg_ff[bzp_pkg::REG_PULL_TWO_Y] <= csr_data;
            bzp_pkg::REG_FINISH_X:   cfg_ff[bzp_pkg::REG_FINISH_X]   <= csr_data;
            bzp_pkg::REG_FINISH_Y:   cfg_ff[bzp_pkg::REG_FINISH_Y]   <= csr_data;
            default: ;
         endcase
      end
   end

   assign coord_x = {cfg_ff[bzp_pkg::REG_FINISH_X], cfg_ff[bzp_pkg::REG_PULL_TWO_X],
                     cfg_ff[bzp_pkg::REG_PULL_ONE_X], cfg_ff[bzp_pkg::REG_START_X]};
   assign coord_y = {cfg_ff[bzp_pkg::REG_FINISH_Y], cfg_ff[bzp_pkg::REG_PULL_TWO_Y],
                     cfg_ff[bzp_pkg::REG_PULL_ONE_Y], cfg_ff[bzp_pkg::REG_START_Y]};

   bzp_coef #(
      .SEGMENTS (SEGMENTS)
   ) u_coef (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_index  (req_sample_index),
      .out_valid (coef_valid),
      .out_ready (coef_ready),
      .out_coef  (coef)
   );

   assign rdy6       = !v6_ff || rsp_ready;
   assign rdy5       = !v5_ff || rdy6;
   assign rdy4       = !v4_ff || rdy5;
   assign coef_ready = rdy4;

   assign ctl.en_prod  = rdy4;
   assign ctl.en_round = rdy5;
   assign ctl.en_sum   = rdy6;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (rdy4) v4_ff <= coef_valid;
         if (rdy5) v5_ff <= v4_ff;
         if (rdy6) v6_ff <= v5_ff;
      end
   end

   bzp_term u_term_x (
      .clock (clock),
      .ctl   (ctl),
      .coef  (coef),
      .coord (coord_x),
      .point (point_x)
   );

   bzp_term u_term_y (
      .clock (clock),
      .ctl   (ctl),
      .coef  (coef),
      .coord (coord_y),
      .point (point_y)
   );

   assign rsp_valid   = v6_ff;
   assign rsp_point_x = point_x;
   assign rsp_point_y = point_y;

`ifndef NO_ASSERTIONS
   a_empty_after_reset: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_valid)
      else $error("sampler: result valid right after reset");
   a_round_to_out: assert property (@(posedge clock) disable iff (reset)
      (v5_ff && rdy6) |=> rsp_valid)
      else $error("sampler: rounded beat lost before output");
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && v5_ff && v6_ff && !rsp_ready) |-> !coef_ready)
      else $error("sampler: full back end still takes weights");
   a_stall_holds_back: assert property (@(posedge clock) disable iff (reset)
      (v6_ff && !rsp_ready && v5_ff) |=> (v5_ff && v6_ff))
      else $error("sampler: stall dropped a beat");
`endif

endmodule

`default_nettype wire

// ===== test/bzp_point_checker.sv =====
// ----------------------------------------------------------------------------
// bzp_point_checker
// Watches the control point, sample and point channels of the Bezier point
// sampler, predicts each point from its own copy of the control points and
// compares every returned point, in order, against the prediction.
// ----------------------------------------------------------------------------
module bzp_point_checker #(
   parameter int SEGMENTS = 100
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [bzp_pkg::REG_IDX_W-1:0]      csr_index,
   input  logic [bzp_pkg::COORD_W-1:0]        csr_data,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [bzp_pkg::IDX_W-1:0]          req_sample_index,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic signed [bzp_pkg::POINT_W-1:0] rsp_point_x,
   input  logic signed [bzp_pkg::POINT_W-1:0] rsp_point_y,
   output int                                 points_pending,
   output int                                 mismatch_count
);

   localparam longint unsigned T_ONE = 64'd1 << bzp_pkg::FRAC_BITS;

   typedef struct packed {
      logic signed [bzp_pkg::POINT_W-1:0] x;
      logic signed [bzp_pkg::POINT_W-1:0] y;
   } curve_point_type;

   logic signed [bzp_pkg::COORD_W-1:0] ctrl_coord [bzp_pkg::NUM_REGS];
   curve_point_type                    expected_points [$];
   curve_point_type                    want;

   // coordinate * weight / 2^48, nearest, halves away from zero
   function automatic int bernstein_term(input int coord, input longint unsigned weight);
      longint unsigned mag;
      longint unsigned scaled;
      mag    = (coord < 0) ? longint'(-coord) : longint'(coord);
      scaled = (mag * weight + (64'd1 << (3 * bzp_pkg::FRAC_BITS - 1)))
               >> (3 * bzp_pkg::FRAC_BITS);
      return (coord < 0) ? -int'(scaled) : int'(scaled);
   endfunction

   function automatic curve_point_type predict_point(input logic [bzp_pkg::IDX_W-1:0] idx);
      longint unsigned step;
      longint unsigned t;
      longint unsigned u;
      longint unsigned weight [4];
      int              sum_x;
      int              sum_y;
      curve_point_type pt;
      step = (idx > SEGMENTS) ? SEGMENTS : idx;
      t = ((step << (bzp_pkg::FRAC_BITS + 1)) + SEGMENTS) / (2 * SEGMENTS);
      if (t > T_ONE) begin
         t = T_ONE;
      end
      u = T_ONE - t;
      weight[0] = u * u * u;
      weight[1] = 3 * u * u * t;
      weight[2] = 3 * u * t * t;
      weight[3] = t * t * t;
      sum_x = 0;
      sum_y = 0;
      for (int k = 0; k < 4; k++) begin
         sum_x += bernstein_term(ctrl_coord[2 * k], weight[k]);
         sum_y += bernstein_term(ctrl_coord[2 * k + 1], weight[k]);
      end
      pt.x = sum_x[bzp_pkg::POINT_W-1:0];
      pt.y = sum_y[bzp_pkg::POINT_W-1:0];
      return pt;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int exp_val);
      $display("[%0t] point check: %s got %0d wanted %0d", $realtime, what, got, exp_val);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (ctrl_coord[k]) begin
            ctrl_coord[k] = '0;
         end
         expected_points.delete();
         mismatch_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            ctrl_coord[csr_index] = csr_data;
         end
         if (req_valid && req_ready) begin
            expected_points.push_back(predict_point(req_sample_index));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               report_mismatch("unexpected point beat, x", rsp_point_x, 0);
            end else begin
               want = expected_points.pop_front();
               if (rsp_point_x !== want.x) begin
                  report_mismatch("point_x", rsp_point_x, want.x);
               end
               if (rsp_point_y !== want.y) begin
                  report_mismatch("point_y", rsp_point_y, want.y);
               end
            end
         end
      end
      points_pending = expected_points.size();
   end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the cubic Bezier point sampler: uses control point sets (reset
// values, extremes, random), sends directed and random sample indexes with
// random gaps and receiver stalls, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int SEGMENTS = 100;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [bzp_pkg::REG_IDX_W-1:0]      csr_index = '0;
   logic [bzp_pkg::COORD_W-1:0]        csr_data = '0;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [bzp_pkg::IDX_W-1:0]          req_sample_index = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic signed [bzp_pkg::POINT_W-1:0] rsp_point_x;
   logic signed [bzp_pkg::POINT_W-1:0] rsp_point_y;

   int points_pending;
   int mismatch_count;
   int req_gap_odds = 0;
   int rsp_stall_odds = 0;
   int probe_index [7] = '{0, 1, SEGMENTS / 2, SEGMENTS - 1, SEGMENTS, SEGMENTS + 1, 127};

   cubic_bezier_point_sampler #(.SEGMENTS(SEGMENTS)) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_index (req_sample_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_point_x      (rsp_point_x),
      .rsp_point_y      (rsp_point_y)
   );

   bzp_point_checker #(.SEGMENTS(SEGMENTS)) point_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_index (req_sample_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_point_x      (rsp_point_x),
      .rsp_point_y      (rsp_point_y),
      .points_pending   (points_pending),
      .mismatch_count   (mismatch_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #4000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // receiver: ready with random stall bursts
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_stall_odds != 0 && $urandom_range(1, rsp_stall_odds) == 1) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   function automatic int rand_coord();
      case ($urandom_range(0, 9))
         0:       return -2048;
         1:       return 2047;
         default: return $urandom_range(0, 4095) - 2048;
      endcase
   endfunction

   // valid stays high on return; caller lowers it
   task automatic write_coord(input logic [bzp_pkg::REG_IDX_W-1:0] index, input int value);
      bit taken;
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value[bzp_pkg::COORD_W-1:0];
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic load_control_points(input int sx, input int sy, input int ax, input int ay,
                                      input int bx, input int by, input int fx, input int fy);
      write_coord(bzp_pkg::REG_START_X, sx);
      write_coord(bzp_pkg::REG_START_Y, sy);
      write_coord(bzp_pkg::REG_PULL_ONE_X, ax);
      write_coord(bzp_pkg::REG_PULL_ONE_Y, ay);
      write_coord(bzp_pkg::REG_PULL_TWO_X, bx);
      write_coord(bzp_pkg::REG_PULL_TWO_Y, by);
      write_coord(bzp_pkg::REG_FINISH_X, fx);
      write_coord(bzp_pkg::REG_FINISH_Y, fy);
      csr_valid <= 1'b0;
   endtask

   // valid stays high on return unless the next beat idles first
   task automatic send_sample(input int idx);
      bit taken;
      if (req_gap_odds != 0 && $urandom_range(1, req_gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_index <= idx[bzp_pkg::IDX_W-1:0];
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic drain_points();
      req_valid <= 1'b0;
      do @(negedge clock); while (points_pending != 0);
      @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // control points at reset value
      send_sample(0);
      send_sample(64);
      send_sample(127);
      drain_points();

      load_control_points(2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047);
      foreach (probe_index[k]) send_sample(probe_index[k]);
      drain_points();

      load_control_points(-2048, -2048, -2048, -2048, -2048, -2048, -2048, -2048);
      foreach (probe_index[k]) send_sample(probe_index[k]);
      drain_points();

      load_control_points(2047, -2048, -2048, 2047, 2047, -2048, -2048, 2047);
      foreach (probe_index[k]) send_sample(probe_index[k]);
      drain_points();

      for (int phase = 0; phase < 12; phase++) begin
         load_control_points(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                             rand_coord(), rand_coord(), rand_coord(), rand_coord());
         if (phase == 11) begin
            req_gap_odds   = 0;
            rsp_stall_odds = 0;
         end else begin
            req_gap_odds   = (phase % 3 == 0) ? 0 : $urandom_range(3, 8);
            rsp_stall_odds = (phase % 4 == 1) ? 0 : $urandom_range(3, 10);
         end
         for (int n = 0; n < 125; n++) begin
            if (phase == 5 && n == 60) begin
               drain_points();
            end
            if ($urandom_range(0, 99) < 85) begin
               send_sample($urandom_range(0, SEGMENTS));
            end else begin
               send_sample($urandom_range(0, 127));
            end
         end
         drain_points();
      end

      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
